FILE: rtl/bmp_pkg.sv
// Package for the binomial-mod-prime block: widths, reset constants, shared types.
// No dependencies.
`default_nettype none
package bmp_pkg;
  localparam int unsigned ValW = 30;
  localparam int unsigned IdxW = 16;
  localparam int unsigned TableEntriesDefault = 65536;
  localparam logic [ValW-1:0] ModulusReset = 30'd1000000007;
  localparam logic [0:0] KindLoad = 1'b0;
  localparam logic [0:0] KindQuery = 1'b1;
  localparam logic [0:0] RegModulus = 1'b0;

  // Request to the shared modular arithmetic unit.
  typedef struct packed {
    logic            start;
    logic            inv;      // 1: invert a, 0: multiply a*b
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
  } arith_req_t;
endpackage
`default_nettype wire

FILE: rtl/bmp_mulmod.sv
// Sequential modular unit: a*b mod m by shift-add after reducing a modulo m,
// or inverse of a mod m by the extended Euclidean algorithm, one bit a cycle.
// Depends on bmp_pkg.
`default_nettype none
module bmp_mulmod (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire bmp_pkg::arith_req_t    req,
  input  wire [bmp_pkg::ValW-1:0]     modulus,
  output logic                        done,
  output logic [bmp_pkg::ValW-1:0]    result
);
  import bmp_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_RED, S_MUL, S_DIV, S_SUB, S_FIX} st_t;
  localparam int unsigned SW = ValW + 2;
  localparam int unsigned WW = 2 * ValW;

  st_t st_r;
  logic inv_r;
  logic [ValW-1:0] acc_r, a_r, b_r;
  logic [4:0] bit_r;
  // Euclid: r0 and r1 stay below 2^30; s values stay within m in magnitude.
  logic [ValW-1:0] r0_r, r1_r, rem_r;
  logic signed [SW-1:0] s0_r, s1_r, sacc_r;

  logic [ValW:0] dbl, dbl_red, add, add_red;
  logic [ValW-1:0] dvsr;
  logic [WW-1:0] dvsr_sh;
  logic take;
  logic [ValW-1:0] rem_nxt;
  logic signed [SW-1:0] sacc_nxt, smod, m_s;

  // Multiply step: acc = 2*acc + a*b[bit], kept below m.
  always_comb begin
    dbl = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    add = dbl_red + {1'b0, a_r};
    add_red = (add >= {1'b0, modulus}) ? add - {1'b0, modulus} : add;
  end

  // Shared shift-subtract step: reduces a modulo m, or divides r0 by r1.
  always_comb begin
    dvsr = (st_r == S_RED) ? modulus : r1_r;
    dvsr_sh = {{ValW{1'b0}}, dvsr} << bit_r;
    take = {{ValW{1'b0}}, rem_r} >= dvsr_sh;
    rem_nxt = take ? rem_r - dvsr_sh[ValW-1:0] : rem_r;
    sacc_nxt = take ? sacc_r - (s1_r <<< bit_r) : sacc_r;
  end

  always_comb begin
    m_s = $signed({2'b0, modulus});
    smod = s0_r;
    if (smod < 0) smod = smod + m_s;
    if (smod >= m_s) smod = smod - m_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st_r == S_FIX);
      case (st_r)
        S_IDLE: begin
          if (req.start) begin
            inv_r <= req.inv;
            if (req.inv) begin
              r0_r <= req.a;
              r1_r <= modulus;
              s0_r <= SW'(1);
              s1_r <= '0;
              st_r <= S_DIV;
            end else begin
              // The multiplicand may be unreduced, so reduce it first.
              rem_r <= req.a;
              b_r <= req.b;
              bit_r <= 5'(ValW - 1);
              st_r <= S_RED;
            end
          end
        end
        S_RED: begin
          rem_r <= rem_nxt;
          if (bit_r == '0) begin
            a_r <= rem_nxt;
            acc_r <= '0;
            bit_r <= 5'(ValW - 1);
            st_r <= S_MUL;
          end else bit_r <= bit_r - 5'd1;
        end
        S_MUL: begin
          acc_r <= b_r[bit_r] ? add_red[ValW-1:0] : dbl_red[ValW-1:0];
          if (bit_r == '0) st_r <= S_FIX;
          else bit_r <= bit_r - 5'd1;
        end
        S_DIV: begin
          if (r1_r == '0) st_r <= S_FIX;
          else begin
            rem_r <= r0_r;
            sacc_r <= s0_r;
            bit_r <= 5'(ValW - 1);
            st_r <= S_SUB;
          end
        end
        S_SUB: begin
          rem_r <= rem_nxt;
          sacc_r <= sacc_nxt;
          if (bit_r == '0) begin
            r0_r <= r1_r;
            r1_r <= rem_nxt;
            s0_r <= s1_r;
            s1_r <= sacc_nxt;
            st_r <= S_DIV;
          end else bit_r <= bit_r - 5'd1;
        end
        S_FIX: begin
          result <= inv_r ? smod[ValW-1:0] : acc_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
    else $error("done held");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> st_r == S_IDLE)
    else $error("done outside idle");
  a_idle_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FIX |=> done) else $error("fix without done");
`endif
endmodule
`default_nettype wire

FILE: rtl/binomial_mod_prime.sv
// Binomial coefficient mod prime from a factorial table held in one RAM.
// Loads: one transfer a cycle while idle, no result. Queries with k above n or a modulus
// below two: result registered from the transfer, or held in S_OUT while the output is taken.
// Other queries: n!/(k!(n-k)!) from table reads, a multiply, a Euclid inverse and a
// multiply in the bit-serial modular unit; one query at a time. Reset (rst_n,
// synchronous) sets modulus to 1000000007; table contents stay undefined.
`default_nettype none
module binomial_mod_prime #(
  parameter int unsigned TABLE_ENTRIES = bmp_pkg::TableEntriesDefault
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_kind,
  input  wire [bmp_pkg::IdxW-1:0]      in_entry_index,
  input  wire [bmp_pkg::ValW-1:0]      in_entry_value,
  input  wire [bmp_pkg::IdxW-1:0]      in_top,
  input  wire [bmp_pkg::IdxW-1:0]      in_choose,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [bmp_pkg::ValW-1:0]     out_binom,
  output logic                         out_k_exceeds_n,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [1:0]                    cfg_paddr,
  input  wire [31:0]                   cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import bmp_pkg::*;
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  typedef enum logic [3:0] {
    S_IDLE, S_RDN, S_RDK, S_RDNK, S_WAITK, S_MUL1, S_INV, S_MUL2, S_OUT
  } st_t;

  logic [ValW-1:0] modulus_r;
  logic [ValW-1:0] mem [TABLE_ENTRIES];
  logic [ValW-1:0] rd_r;
  logic [AW-1:0] rd_addr;
  st_t st_r;
  logic [IdxW-1:0] n_r, k_r;
  logic [ValW-1:0] num_r, kf_r;
  // A finished result waits here while the output register is still taken.
  logic [ValW-1:0] res_r;
  logic flag_r;
  arith_req_t req;
  logic done;
  logic [ValW-1:0] ares;
  logic quick, slot_free, out_load, out_flag_nxt;
  logic [ValW-1:0] out_binom_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'b00) ? {2'b0, modulus_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) modulus_r <= ModulusReset;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00)
      modulus_r <= cfg_pwdata[ValW-1:0];
  end

  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    case (st_r)
      S_RDK:   rd_addr = AW'(k_r);
      S_RDNK:  rd_addr = AW'(n_r - k_r);
      default: rd_addr = AW'(n_r);
    endcase
  end

  logic wr_en, in_fire;
  assign in_fire = in_valid && in_ready;
  assign wr_en = in_fire && in_kind == KindLoad && 32'(in_entry_index) < TABLE_ENTRIES;
  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(in_entry_index)] <= in_entry_value;
    rd_r <= mem[rd_addr];
  end

  function automatic logic [ValW-1:0] oob(input logic [IdxW-1:0] i, input logic [ValW-1:0] v);
    return (32'(i) < TABLE_ENTRIES) ? v : '0;
  endfunction

  always_comb begin
    req = '0;
    case (st_r)
      S_WAITK: begin req.start = 1'b1; req.a = kf_r; req.b = oob(n_r - k_r, rd_r); end
      S_MUL1: if (done) begin req.start = 1'b1; req.inv = 1'b1; req.a = ares; end
      S_INV: if (done) begin req.start = 1'b1; req.a = num_r; req.b = ares; end
      default: req = '0;
    endcase
  end

  bmp_mulmod u_arith (.clk, .rst_n, .req, .modulus(modulus_r), .done, .result(ares));

  assign quick = (in_choose > in_top) || (modulus_r < 30'd2);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    out_load = 1'b0;
    out_binom_nxt = '0;
    out_flag_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_fire && in_kind == KindQuery && quick) begin
        out_load = slot_free;
        out_flag_nxt = in_choose > in_top;
      end
      S_MUL2: if (done) begin
        out_load = slot_free;
        out_binom_nxt = ares;
      end
      S_OUT: begin
        out_load = slot_free;
        out_binom_nxt = res_r;
        out_flag_nxt = flag_r;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_binom <= out_binom_nxt;
        out_k_exceeds_n <= out_flag_nxt;
      end else if (out_ready) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (in_fire && in_kind == KindQuery) begin
          n_r <= in_top; k_r <= in_choose;
          if (!quick) st_r <= S_RDN;
          else if (!slot_free) begin
            res_r <= '0;
            flag_r <= in_choose > in_top;
            st_r <= S_OUT;
          end
        end
        S_RDN:  st_r <= S_RDK;
        S_RDK:  begin num_r <= oob(n_r, rd_r); st_r <= S_RDNK; end
        S_RDNK: begin kf_r <= oob(k_r, rd_r); st_r <= S_WAITK; end
        S_WAITK: st_r <= S_MUL1;
        S_MUL1: if (done) st_r <= S_INV;
        S_INV:  if (done) st_r <= S_MUL2;
        S_MUL2: if (done) begin
          res_r <= ares;
          flag_r <= 1'b0;
          st_r <= slot_free ? S_IDLE : S_OUT;
        end
        S_OUT:  if (slot_free) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_k_exceeds_n |-> out_binom == '0) else $error("flag with nonzero");
  a_result_lt_m: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && modulus_r > 30'd1 |-> out_binom < modulus_r) else $error("unreduced");
`endif
endmodule
`default_nettype wire
